>>> design/stereo_pan_volume_macros.svh
// ---------------------------------------------------------------------------
// stereo_pan_volume assertion macros
// Concurrent check shorthands used by the stereo_pan_volume top module.
// ---------------------------------------------------------------------------
`ifndef STEREO_PAN_VOLUME_MACROS_SVH
`define STEREO_PAN_VOLUME_MACROS_SVH

// same-cycle implication, gated by reset
`define SPV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, gated by reset
`define SPV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/spv_pkg.sv
// ---------------------------------------------------------------------------
// spv_pkg
// Shared types, constants and arithmetic helpers of the stereo pan/volume block.
// ---------------------------------------------------------------------------
package spv_pkg;

  localparam int unsigned VolW  = 8;
  localparam int unsigned PanW  = 14;  // saturated pan, 0 .. 0x2000
  localparam int unsigned IdxW  = 6;   // curve index, 0 .. 33
  localparam int unsigned CfgIdxW = 8;

  localparam logic [PanW-1:0] PAN_FULL = 14'h2000;
  localparam logic [VolW-1:0] MASTER_RESET   = 8'hC0;
  localparam logic [VolW-1:0] VELOCITY_RESET = 8'hB3;

  localparam logic [CfgIdxW-1:0] CFG_MAIN_GAIN     = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_NOTE_VELOCITY = 8'd1;

  // per-stage load strobes of the datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // high byte of an 8x8 product
  function automatic logic [VolW-1:0] hi_mul(input logic [VolW-1:0] a,
                                             input logic [VolW-1:0] b);
    logic [2*VolW-1:0] p;
    p = a * b;
    return p[2*VolW-1:VolW];
  endfunction

  // pan curve ROM, 34 entries
  function automatic logic [VolW-1:0] pan_curve(input logic [IdxW-1:0] idx);
    logic [VolW-1:0] v;
    case (idx)
      6'd0:  v = 8'd0;    6'd1:  v = 8'd1;    6'd2:  v = 8'd2;    6'd3:  v = 8'd3;
      6'd4:  v = 8'd5;    6'd5:  v = 8'd8;    6'd6:  v = 8'd12;   6'd7:  v = 8'd16;
      6'd8:  v = 8'd21;   6'd9:  v = 8'd27;   6'd10: v = 8'd33;   6'd11: v = 8'd40;
      6'd12: v = 8'd47;   6'd13: v = 8'd55;   6'd14: v = 8'd63;   6'd15: v = 8'd72;
      6'd16: v = 8'd81;   6'd17: v = 8'd89;   6'd18: v = 8'd96;   6'd19: v = 8'd102;
      6'd20: v = 8'd107;  6'd21: v = 8'd111;  6'd22: v = 8'd114;  6'd23: v = 8'd117;
      6'd24: v = 8'd119;  6'd25: v = 8'd121;  6'd26: v = 8'd122;  6'd27: v = 8'd123;
      6'd28: v = 8'd124;  6'd29: v = 8'd125;  6'd30: v = 8'd126;  6'd31: v = 8'd126;
      6'd32: v = 8'd127;  6'd33: v = 8'd127;
      default: v = 8'd127;
    endcase
    return v;
  endfunction

endpackage

>>> design/spv_vol_scale.sv
// ---------------------------------------------------------------------------
// spv_vol_scale
// Three-stage volume chain: velocity scale, master scale, squaring.
// ---------------------------------------------------------------------------
module spv_vol_scale (
  input  logic                   clk,
  input  spv_pkg::stage_en_t     en,
  input  logic [spv_pkg::VolW-1:0] channel_volume,
  input  logic [spv_pkg::VolW-1:0] note_velocity,
  input  logic [spv_pkg::VolW-1:0] main_gain,
  output logic [spv_pkg::VolW-1:0] scaled
);
  import spv_pkg::*;

  logic [VolW-1:0] v1_r, v1_nxt;
  logic [VolW-1:0] v2_r, v2_nxt;
  logic [VolW-1:0] v3_r, v3_nxt;

  always_comb begin
    v1_nxt = hi_mul(note_velocity, channel_volume);
    v2_nxt = hi_mul(v1_r, main_gain);
    v3_nxt = hi_mul(v2_r, v2_r);
  end

  always_ff @(posedge clk) begin
    if (en.s1) v1_r <= v1_nxt;
    if (en.s2) v2_r <= v2_nxt;
    if (en.s3) v3_r <= v3_nxt;
  end

  assign scaled = v3_r;

endmodule

>>> design/spv_pan_side.sv
// ---------------------------------------------------------------------------
// spv_pan_side
// One stereo side: curve lookup, linear interpolation, volume scale, invert.
// ---------------------------------------------------------------------------
module spv_pan_side (
  input  logic                     clk,
  input  spv_pkg::stage_en_t       en,
  input  logic [spv_pkg::PanW-1:0] pan,
  input  logic                     invert,
  input  logic [spv_pkg::VolW-1:0] scaled,   // valid at stage 3
  output logic [spv_pkg::VolW-1:0] level
);
  import spv_pkg::*;

  logic [IdxW-1:0] idx;
  logic [VolW-1:0] here, there;

  logic [VolW-1:0] here_r, here_nxt;
  logic [VolW-1:0] diff_r, diff_nxt;
  logic [VolW-1:0] frac_r;
  logic [VolW-1:0] mult2_r, mult2_nxt;
  logic [VolW-1:0] mult3_r;
  logic [VolW-1:0] level_r, level_nxt;
  logic            inv1_r, inv2_r, inv3_r;
  logic [VolW-1:0] prod;

  always_comb begin
    idx      = pan[PanW-1:VolW];
    here     = pan_curve(idx);
    there    = pan_curve(idx + 6'd1);
    here_nxt = here;
    diff_nxt = there - here;
    mult2_nxt = here_r + hi_mul(diff_r, frac_r);
    prod      = hi_mul(mult3_r, scaled);
    // surround invert: two's complement negate mod 256
    level_nxt = inv3_r ? (8'd0 - prod) : prod;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      here_r <= here_nxt;
      diff_r <= diff_nxt;
      frac_r <= pan[VolW-1:0];
      inv1_r <= invert;
    end
    if (en.s2) begin
      mult2_r <= mult2_nxt;
      inv2_r  <= inv1_r;
    end
    if (en.s3) begin
      mult3_r <= mult2_r;
      inv3_r  <= inv2_r;
    end
    if (en.s4) level_r <= level_nxt;
  end

  assign level = level_r;

endmodule

>>> design/stereo_pan_volume.sv
// ---------------------------------------------------------------------------
// stereo_pan_volume
// Pan/volume to left and right DSP volume bytes, four-stage pipeline.
// ---------------------------------------------------------------------------
// Channel | Dir | Handshake              | Payload
// in_     | in  | in_tvalid/in_tready    | tdata: volume, coarse, fine; tuser: inverts
// out_    | out | out_tvalid/out_tready  | tdata: left_level, right_level
// cfg_    | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// Requests pass stages 1 to 4 in order; one request per cycle sustained while
// out_tready is high. Stage 4 is the output register; each stage loads when it
// is empty or the stage after it moves, so a held output fills bubbles upstream.
// rst_n (synchronous) clears stage valids and loads the register reset values.
// cfg_ready is always high; writes take effect on the next cycle.
// ---------------------------------------------------------------------------
module stereo_pan_volume (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] channel_volume, [15:8] pan_coarse, [23:16] pan_fine
  input  logic [1:0]  in_tuser,   // [0] invert_left, [1] invert_right
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] left_level, [15:8] right_level
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [spv_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [spv_pkg::VolW-1:0]    cfg_data
);
  import spv_pkg::*;

  `include "stereo_pan_volume_macros.svh"

  logic [VolW-1:0] master_r, master_nxt;
  logic [VolW-1:0] velocity_r, velocity_nxt;

  logic [3:0] vld_r, vld_nxt;   // stage valids, bit 0 = stage 1
  logic [3:0] rdy;
  logic [3:0] feed;
  stage_en_t  en;

  logic [15:0]     pan_raw;
  logic [PanW-1:0] pan_right, pan_left;
  logic [VolW-1:0] scaled, left_level, right_level;

  // config writes
  assign cfg_ready = 1'b1;
  always_comb begin
    master_nxt   = master_r;
    velocity_nxt = velocity_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MAIN_GAIN:     master_nxt   = cfg_data;
        CFG_NOTE_VELOCITY: velocity_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    rdy[3] = !vld_r[3] || out_tready;
    rdy[2] = !vld_r[2] || rdy[3];
    rdy[1] = !vld_r[1] || rdy[2];
    rdy[0] = !vld_r[0] || rdy[1];
    feed   = {vld_r[2:0], in_tvalid};
    for (int k = 0; k < 4; k++) begin
      vld_nxt[k] = rdy[k] ? feed[k] : vld_r[k];
    end
    en.s1 = rdy[0] && feed[0];
    en.s2 = rdy[1] && feed[1];
    en.s3 = rdy[2] && feed[2];
    en.s4 = rdy[3] && feed[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      master_r   <= MASTER_RESET;
      velocity_r <= VELOCITY_RESET;
    end else begin
      vld_r      <= vld_nxt;
      master_r   <= master_nxt;
      velocity_r <= velocity_nxt;
    end
  end

  // pan saturation; left side mirrors around full right
  always_comb begin
    pan_raw   = {in_tdata[15:8], in_tdata[23:16]};
    pan_right = (pan_raw > {2'b00, PAN_FULL}) ? PAN_FULL : pan_raw[PanW-1:0];
    pan_left  = PAN_FULL - pan_right;
  end

  spv_vol_scale u_vol (
    .clk            (clk),
    .en             (en),
    .channel_volume (in_tdata[7:0]),
    .note_velocity  (velocity_r),
    .main_gain      (master_r),
    .scaled         (scaled)
  );

  spv_pan_side u_left (
    .clk    (clk),
    .en     (en),
    .pan    (pan_left),
    .invert (in_tuser[0]),
    .scaled (scaled),
    .level  (left_level)
  );

  spv_pan_side u_right (
    .clk    (clk),
    .en     (en),
    .pan    (pan_right),
    .invert (in_tuser[1]),
    .scaled (scaled),
    .level  (right_level)
  );

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[3];
  assign out_tdata  = {right_level, left_level};

  `SPV_ASSERT_NOW(a_empty_out_ready, !out_tvalid, in_tready, "input blocked with empty output")
  `SPV_ASSERT_NEXT(a_accept_fills_s1, in_tvalid && in_tready, vld_r[0], "accepted request lost")
  `SPV_ASSERT_NOW(a_full_stall_blocks, (vld_r == 4'hF) && !out_tready, !in_tready,
                  "input taken while pipeline full and stalled")

endmodule
